>>> hdl/vsc_pkg.sv
`default_nettype none
package vsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int MAG_W     = 33;           // |new - center|
  localparam int SQ_W      = 68;           // sum of squares, padded to even
  localparam int ROOT_W    = SQ_W / 2;     // 34
  localparam int SREM_W    = ROOT_W + 1;   // square root partial remainder
  localparam int DIST_W    = ROOT_W + 1;   // root + particle radius
  localparam int RB_W      = 15 + FRAC_BITS;
  localparam int NUM_W     = MAG_W + RB_W; // 64
  localparam int QUO_W     = MAG_W;        // quotient stays below the magnitude
  localparam int DREM_W    = DIST_W;
  localparam int WIDE_W    = 35;

  typedef enum logic [2:0] {
    REG_GRAV_X  = 3'd0,
    REG_GRAV_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_BOUND_R = 3'd4,
    REG_PART_R  = 3'd5
  } reg_idx_t;

  // everything an item carries past the arithmetic cells
  typedef struct packed {
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;
    logic                    neg_x;
    logic                    neg_y;
    logic                    mov;
    logic                    last;
  } meta_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = -WIDE_W'(33'sh080000000);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/vsc_sqrt_cell.sv
`default_nettype none
// one root bit per cell, two radicand bits consumed
module vsc_sqrt_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        vld_i,
  input  wire logic [vsc_pkg::SQ_W-1:0]    s_i,
  input  wire logic [vsc_pkg::SREM_W-1:0]  rem_i,
  input  wire logic [vsc_pkg::ROOT_W-1:0]  root_i,
  input  wire vsc_pkg::meta_t              meta_i,
  output logic                             vld_o,
  output logic [vsc_pkg::SQ_W-1:0]         s_o,
  output logic [vsc_pkg::SREM_W-1:0]       rem_o,
  output logic [vsc_pkg::ROOT_W-1:0]       root_o,
  output vsc_pkg::meta_t                   meta_o
);
  logic [vsc_pkg::SREM_W+1:0] cur;
  logic [vsc_pkg::SREM_W+1:0] trial;
  logic                       take;

  assign cur   = {rem_i, s_i[vsc_pkg::SQ_W-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign take  = cur >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
    if (en) begin
      s_o    <= {s_i[vsc_pkg::SQ_W-3:0], 2'b00};
      rem_o  <= take ? vsc_pkg::SREM_W'(cur - trial) : cur[vsc_pkg::SREM_W-1:0];
      root_o <= {root_i[vsc_pkg::ROOT_W-2:0], take};
      meta_o <= meta_i;
    end
  end
endmodule
`default_nettype wire

>>> hdl/vsc_div_cell.sv
`default_nettype none
// one quotient bit per cell for both axes; nq holds numerator bits then quotient bits
module vsc_div_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        vld_i,
  input  wire logic [vsc_pkg::DIST_W-1:0]  d_i,
  input  wire logic [vsc_pkg::DREM_W-1:0]  rem_i [2],
  input  wire logic [vsc_pkg::QUO_W-1:0]   nq_i [2],
  input  wire vsc_pkg::meta_t              meta_i,
  output logic                             vld_o,
  output logic [vsc_pkg::DIST_W-1:0]       d_o,
  output logic [vsc_pkg::DREM_W-1:0]       rem_o [2],
  output logic [vsc_pkg::QUO_W-1:0]        nq_o [2],
  output vsc_pkg::meta_t                   meta_o
);
  logic [vsc_pkg::DREM_W:0] cur [2];
  logic                     take [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cur[k]  = {rem_i[k], nq_i[k][vsc_pkg::QUO_W-1]};
      take[k] = cur[k] >= {1'b0, d_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
    if (en) begin
      d_o    <= d_i;
      meta_o <= meta_i;
      for (int k = 0; k < 2; k++) begin
        rem_o[k] <= take[k] ? vsc_pkg::DREM_W'(cur[k] - {1'b0, d_i})
                            : cur[k][vsc_pkg::DREM_W-1:0];
        nq_o[k]  <= {nq_i[k][vsc_pkg::QUO_W-2:0], take[k]};
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/verlet_step_with_circular_bound_top.sv
`default_nettype none
// One position-Verlet step with a circular boundary, one particle per item.
// Input: in_tdata = {old_y, old_x, cur_y, cur_x}, in_tuser = is_static,
// in_tlast = last of substep. Output: out_tdata = {prev_y, prev_x, new_y,
// new_x}, out_tuser = clamped, out_tlast = frame_done.
// Config: cfg_index/cfg_data written when cfg_valid is high (cfg_ready is
// always high); write only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. Path from
// accept to out_tvalid: stages 1 to 4, the 34-cell square root chain, stage 5,
// the 33-cell divider chain (one bit per cell), then the output
// register.
// Reset clears all valid bits and loads the default configuration.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_tready drops in the same cycle; nothing is lost or duplicated.
module verlet_step_with_circular_bound_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // cur_x, cur_y, old_x, old_y
  input  wire logic [0:0]   in_tuser,   // is_static
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // new_x, new_y, prev_x, prev_y
  output logic [0:0]        out_tuser,  // clamped
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  localparam int NS = vsc_pkg::ROOT_W;
  localparam int ND = vsc_pkg::QUO_W;
  localparam int W  = vsc_pkg::WIDE_W;
  localparam int F  = vsc_pkg::FRAC_BITS;

  logic signed [23:0] grav_x_r, grav_y_r;
  logic [14:0]        cen_x_r, cen_y_r, bound_r;
  logic [7:0]         prad_r;
  logic               en;

  assign cfg_ready = 1'b1;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_x_r <= 24'sd0;
      grav_y_r <= 24'sd85;
      cen_x_r  <= 15'd400;
      cen_y_r  <= 15'd300;
      bound_r  <= 15'd400;
      prad_r   <= 8'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        vsc_pkg::REG_GRAV_X:   grav_x_r <= cfg_data;
        vsc_pkg::REG_GRAV_Y:   grav_y_r <= cfg_data;
        vsc_pkg::REG_CENTER_X: cen_x_r  <= cfg_data[14:0];
        vsc_pkg::REG_CENTER_Y: cen_y_r  <= cfg_data[14:0];
        vsc_pkg::REG_BOUND_R:  bound_r  <= cfg_data[14:0];
        vsc_pkg::REG_PART_R:   prad_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [30:0]        kx, ky;
  logic [vsc_pkg::RB_W-1:0] rb;
  assign kx = {cen_x_r, {F{1'b0}}};
  assign ky = {cen_y_r, {F{1'b0}}};
  assign rb = {bound_r, {F{1'b0}}};

  // stage 1: Verlet sum
  logic signed [31:0] cx, cy, ox, oy;
  logic signed [W-1:0] sx, sy;
  assign cx = in_tdata[31:0];
  assign cy = in_tdata[63:32];
  assign ox = in_tdata[95:64];
  assign oy = in_tdata[127:96];
  assign sx = {{2{cx[31]}}, cx, 1'b0} - {{3{ox[31]}}, ox} + W'(grav_x_r);
  assign sy = {{2{cy[31]}}, cy, 1'b0} - {{3{oy[31]}}, oy} + W'(grav_y_r);

  vsc_pkg::meta_t m1_r, m2_r, m3_r, m4_r, m5_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r       <= '0;
      m1_r.mov   <= !in_tuser[0];
      m1_r.last  <= in_tlast;
      if (in_tuser[0]) begin
        m1_r.nx <= cx;
        m1_r.ny <= cy;
        m1_r.px <= ox;
        m1_r.py <= oy;
      end else begin
        m1_r.nx <= vsc_pkg::sat32(sx);
        m1_r.ny <= vsc_pkg::sat32(sy);
        m1_r.px <= cx;
        m1_r.py <= cy;
      end
    end
  end

  // stage 2: offset from center and magnitudes
  logic signed [32:0] dx, dy;
  assign dx = {m1_r.nx[31], m1_r.nx} - $signed({2'b00, kx});
  assign dy = {m1_r.ny[31], m1_r.ny} - $signed({2'b00, ky});

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r       <= m1_r;
      m2_r.neg_x <= dx[32];
      m2_r.neg_y <= dy[32];
      m2_r.ax    <= dx[32] ? 33'(-dx) : 33'(dx);
      m2_r.ay    <= dy[32] ? 33'(-dy) : 33'(dy);
    end
  end

  // stage 3: squares; stage 4: sum
  logic [2*vsc_pkg::MAG_W-1:0] sqx_r, sqy_r;
  logic [vsc_pkg::SQ_W-1:0]    ss_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m3_r  <= m2_r;
      sqx_r <= m2_r.ax * m2_r.ax;
      sqy_r <= m2_r.ay * m2_r.ay;
      m4_r  <= m3_r;
      ss_r  <= vsc_pkg::SQ_W'(sqx_r) + vsc_pkg::SQ_W'(sqy_r);
    end
  end

  // square root chain
  logic                         sv   [NS+1];
  logic [vsc_pkg::SQ_W-1:0]     ssc  [NS+1];
  logic [vsc_pkg::SREM_W-1:0]   srem [NS+1];
  logic [vsc_pkg::ROOT_W-1:0]   sroot[NS+1];
  vsc_pkg::meta_t               sm   [NS+1];

  assign sv[0]    = v4_r;
  assign ssc[0]   = ss_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sm[0]    = m4_r;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    vsc_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .vld_i(sv[i]), .s_i(ssc[i]), .rem_i(srem[i]), .root_i(sroot[i]), .meta_i(sm[i]),
      .vld_o(sv[i+1]), .s_o(ssc[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]),
      .meta_o(sm[i+1])
    );
  end

  // stage 5: distance and numerators
  logic [vsc_pkg::DIST_W-1:0] d5_r;
  logic [vsc_pkg::NUM_W-1:0]  nmx_r, nmy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= sv[NS];
    end
    if (en) begin
      m5_r  <= sm[NS];
      d5_r  <= {1'b0, sroot[NS]} + (vsc_pkg::DIST_W'(prad_r) << F);
      nmx_r <= sm[NS].ax * rb;
      nmy_r <= sm[NS].ay * rb;
    end
  end

  // divider chain
  logic                        dv   [ND+1];
  logic [vsc_pkg::DIST_W-1:0]  dd   [ND+1];
  logic [vsc_pkg::DREM_W-1:0]  drem [ND+1][2];
  logic [vsc_pkg::QUO_W-1:0]   dnq  [ND+1][2];
  vsc_pkg::meta_t              dm   [ND+1];

  assign dv[0]      = v5_r;
  assign dd[0]      = d5_r;
  assign drem[0][0] = vsc_pkg::DREM_W'(nmx_r[vsc_pkg::NUM_W-1:ND]);
  assign drem[0][1] = vsc_pkg::DREM_W'(nmy_r[vsc_pkg::NUM_W-1:ND]);
  assign dnq[0][0]  = nmx_r[ND-1:0];
  assign dnq[0][1]  = nmy_r[ND-1:0];
  assign dm[0]      = m5_r;

  for (genvar j = 0; j < ND; j++) begin : g_div
    vsc_div_cell u_cell (
      .clk, .rst_n, .en,
      .vld_i(dv[j]), .d_i(dd[j]), .rem_i(drem[j]), .nq_i(dnq[j]), .meta_i(dm[j]),
      .vld_o(dv[j+1]), .d_o(dd[j+1]), .rem_o(drem[j+1]), .nq_o(dnq[j+1]),
      .meta_o(dm[j+1])
    );
  end

  // final: projection and output register
  vsc_pkg::meta_t     fm;
  logic               clamp_c;
  logic signed [W-1:0] px_w, py_w;
  assign fm      = dm[ND];
  assign clamp_c = fm.mov && (dd[ND] > vsc_pkg::DIST_W'(rb));
  assign px_w = fm.neg_x ? $signed(W'(kx)) - $signed(W'(dnq[ND][0]))
                         : $signed(W'(kx)) + $signed(W'(dnq[ND][0]));
  assign py_w = fm.neg_y ? $signed(W'(ky)) - $signed(W'(dnq[ND][1]))
                         : $signed(W'(ky)) + $signed(W'(dnq[ND][1]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= dv[ND];
    end
    if (en) begin
      out_tdata[31:0]   <= clamp_c ? vsc_pkg::sat32(px_w) : fm.nx;
      out_tdata[63:32]  <= clamp_c ? vsc_pkg::sat32(py_w) : fm.ny;
      out_tdata[95:64]  <= fm.px;
      out_tdata[127:96] <= fm.py;
      out_tuser[0]      <= clamp_c;
      out_tlast         <= fm.last;
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");
  a_clamp_moving: assert property (@(posedge clk) disable iff (!rst_n)
    dv[ND] && clamp_c |-> fm.mov)
    else $error("static particle clamped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");
  a_static_pass: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv[ND] && !fm.mov |=> out_tuser[0] == 1'b0)
    else $error("static result flagged clamped");

endmodule
`default_nettype wire

>>> sim/verlet_step_with_circular_bound_top_test.sv
`timescale 1ns / 100ps
module verlet_step_with_circular_bound_top_test;

  localparam int         LATENCY_WAIT = 90;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASE_ITEMS  = 78;
  localparam int         N_DIR        = 9;
  localparam logic [2:0] IDX_UNUSED_A = 3'd6;
  localparam logic [2:0] IDX_UNUSED_B = 3'd7;

  typedef struct {
    logic signed [31:0] cur_x, cur_y, old_x, old_y;
    logic               is_static, last;
  } particle_t;

  typedef struct {
    logic signed [31:0] new_x, new_y, prev_x, prev_y;
    logic               clamped, frame_done;
  } motion_t;

  typedef struct {
    particle_t p;
    bit        typed;
    motion_t   r;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;  // cur_x, cur_y, old_x, old_y
  logic [0:0]   in_tuser = '0;  // is_static
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;      // new_x, new_y, prev_x, prev_y
  logic [0:0]   out_tuser;      // clamped
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;

  // register copies
  longint grav_x, grav_y, ctr_x, ctr_y, bnd_r, part_r;

  motion_t  motion_q[$];
  int       n_errors = 0;
  int       n_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_reqs = 0;
  int       hold_seen = 0;
  int       hold_cnt = 0;
  dir_row_t dir_tab[N_DIR];

  verlet_step_with_circular_bound_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cnt  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      vsc_pkg::REG_GRAV_X:   grav_x = longint'($signed(val));
      vsc_pkg::REG_GRAV_Y:   grav_y = longint'($signed(val));
      vsc_pkg::REG_CENTER_X: ctr_x  = longint'(val[14:0]);
      vsc_pkg::REG_CENTER_Y: ctr_y  = longint'(val[14:0]);
      vsc_pkg::REG_BOUND_R:  bnd_r  = longint'(val[14:0]);
      vsc_pkg::REG_PART_R:   part_r = longint'(val[7:0]);
      default: ;
    endcase
  endfunction

  function automatic motion_t step_particle(particle_t p);
    motion_t      r;
    longint       cx, cy, ox, oy, kx, ky, nx, ny, dx, dy;
    logic [127:0] ax, ay, s, rb, d, qx, qy, lo, hi, mid;
    cx = p.cur_x; cy = p.cur_y; ox = p.old_x; oy = p.old_y;
    r.frame_done = p.last;
    r.clamped    = 1'b0;
    if (p.is_static) begin
      r.new_x = p.cur_x; r.new_y = p.cur_y;
      r.prev_x = p.old_x; r.prev_y = p.old_y;
      return r;
    end
    r.prev_x = p.cur_x; r.prev_y = p.cur_y;
    kx = ctr_x <<< vsc_pkg::FRAC_BITS;
    ky = ctr_y <<< vsc_pkg::FRAC_BITS;
    rb = 128'(bnd_r) << vsc_pkg::FRAC_BITS;
    nx = clip32(2 * cx - ox + grav_x);
    ny = clip32(2 * cy - oy + grav_y);
    dx = nx - kx;
    dy = ny - ky;
    ax = 128'(dx < 0 ? -dx : dx);
    ay = 128'(dy < 0 ? -dy : dy);
    s  = ax * ax + ay * ay;
    lo = 0;
    hi = 128'(1) << 42;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    d = lo + (128'(part_r) << vsc_pkg::FRAC_BITS);
    if (d > rb) begin
      qx = (ax * rb) / d;
      qy = (ay * rb) / d;
      nx = clip32(kx + (dx < 0 ? -longint'(qx) : longint'(qx)));
      ny = clip32(ky + (dy < 0 ? -longint'(qy) : longint'(qy)));
      r.clamped = 1'b1;
    end
    r.new_x = nx[31:0];
    r.new_y = ny[31:0];
    return r;
  endfunction

  function automatic particle_t gen_particle();
    particle_t p;
    longint    kx, ky;
    kx = ctr_x <<< vsc_pkg::FRAC_BITS;
    ky = ctr_y <<< vsc_pkg::FRAC_BITS;
    if ($urandom_range(9) == 0) begin
      p.cur_x = $urandom; p.cur_y = $urandom;
      p.old_x = $urandom; p.old_y = $urandom;
      p.is_static = 1'($urandom_range(1));
    end else begin
      // around the circle, small velocity
      p.cur_x = 32'(kx + longint'($signed(32'($urandom)) >>> $urandom_range(4, 20)));
      p.cur_y = 32'(ky + longint'($signed(32'($urandom)) >>> $urandom_range(4, 20)));
      p.old_x = p.cur_x - ($signed(32'($urandom)) >>> $urandom_range(10, 30));
      p.old_y = p.cur_y - ($signed(32'($urandom)) >>> $urandom_range(10, 30));
      p.is_static = ($urandom_range(7) == 0);
    end
    p.last = ($urandom_range(15) == 0);
    return p;
  endfunction

  task automatic send_particle(particle_t p, motion_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {p.old_y, p.old_x, p.cur_y, p.cur_x};
    in_tuser  <= p.is_static;
    in_tlast  <= p.last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    motion_q.push_back(r);
  endtask

  task automatic send_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (motion_q.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    set_reg(idx, val);
  endtask

  task automatic apply_setting(int gx, int gy, int cx, int cy, int br, int pr);
    cfg_write(vsc_pkg::REG_GRAV_X, 24'(gx));
    cfg_write(vsc_pkg::REG_GRAV_Y, 24'(gy));
    cfg_write(vsc_pkg::REG_CENTER_X, 24'(cx));
    cfg_write(vsc_pkg::REG_CENTER_Y, 24'(cy));
    cfg_write(vsc_pkg::REG_BOUND_R, 24'(br));
    cfg_write(vsc_pkg::REG_PART_R, 24'(pr));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  always @(negedge clk) begin
    motion_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (motion_q.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 32'h0);
      end else begin
        w = motion_q.pop_front();
        if (out_tdata[31:0] !== w.new_x) report_mismatch("new_x", out_tdata[31:0], w.new_x);
        if (out_tdata[63:32] !== w.new_y) report_mismatch("new_y", out_tdata[63:32], w.new_y);
        if (out_tdata[95:64] !== w.prev_x)
          report_mismatch("prev_x", out_tdata[95:64], w.prev_x);
        if (out_tdata[127:96] !== w.prev_y)
          report_mismatch("prev_y", out_tdata[127:96], w.prev_y);
        if (out_tuser[0] !== w.clamped)
          report_mismatch("clamped", 32'(out_tuser[0]), 32'(w.clamped));
        if (out_tlast !== w.frame_done)
          report_mismatch("frame_done", 32'(out_tlast), 32'(w.frame_done));
      end
    end
  end

  initial begin
    particle_t p;
    motion_t   none;
    none = '{0, 0, 0, 0, 0, 0};
    grav_x = 0; grav_y = 85; ctr_x = 400; ctr_y = 300; bnd_r = 400; part_r = 3;

    // static rows pass unchanged; a resting particle at the center only falls
    dir_tab[0] = '{'{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1, 1}, 1,
                   '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 1}};
    dir_tab[1] = '{'{0, 0, 0, 0, 1, 0}, 1, '{0, 0, 0, 0, 0, 0}};
    dir_tab[2] = '{'{32'sh01900000, 32'sh012c0000, 32'sh01900000, 32'sh012c0000, 0, 0}, 1,
                   '{32'sh01900000, 32'sh012c0055, 32'sh01900000, 32'sh012c0000, 0, 0}};
    // saturation both ways, far outside, all ones
    dir_tab[3] = '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0}, 0, none};
    dir_tab[4] = '{'{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 1}, 0, none};
    dir_tab[5] = '{'{0, 0, 0, 0, 0, 0}, 0, none};
    dir_tab[6] = '{'{-1, -1, 0, 0, 0, 1}, 0, none};
    dir_tab[7] = '{'{32'sh01000000, 32'sh01000000, 32'sh7fffffff, 32'sh80000000, 0, 1}, 0, none};
    dir_tab[8] = '{'{32'sh12345678, -32'sh1234567, 32'sh0f0f0f0f, -32'sh0f0f0f0, 1, 0}, 0, none};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out-of-list indexes are ignored
    cfg_write(IDX_UNUSED_A, 24'hffffff);
    cfg_write(IDX_UNUSED_B, 24'h000000);
    cfg_valid <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 61 : 0;
      recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 24 : 0;
      case (ph)
        1: apply_setting(-8388608, 8388607, 0, 0, 32767, 255);
        2: apply_setting(8388607, -8388608, 32767, 32767, 0, 0);
        3: apply_setting(1000, 85, 400, 300, 400, 3);
        4: apply_setting(-300, 20000, 16384, 100, 2000, 128);
        default: ;
      endcase
      if (ph == 3) begin
        hold_reqs = hold_reqs + 1;
        send_idle_pct = 0;
      end
      if (ph == 0) begin
        for (int i = 0; i < N_DIR; i++) begin
          send_gap();
          send_particle(dir_tab[i].p,
                        dir_tab[i].typed ? dir_tab[i].r : step_particle(dir_tab[i].p));
        end
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        p = gen_particle();
        send_gap();
        send_particle(p, step_particle(p));
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> verlet_step_with_circular_bound_top.f
hdl/vsc_pkg.sv
hdl/vsc_sqrt_cell.sv
hdl/vsc_div_cell.sv
hdl/verlet_step_with_circular_bound_top.sv
sim/verlet_step_with_circular_bound_top_test.sv
